/* rtl/dbt_pkg.sv */
// Shared types and constants for the doorbell device table.
package dbt_pkg;

   localparam int CMD_WIDTH  = 3;
   localparam int TYPE_WIDTH = 2;
   localparam int QIDX_WIDTH = 4;
   localparam int OUT_WIDTH  = 32;

   localparam logic [TYPE_WIDTH-1:0] MAX_DEV_TYPE = 2'd2;

   typedef enum logic [CMD_WIDTH-1:0] {
      CMD_ADD    = 3'd0,
      CMD_DELETE = 3'd1,
      CMD_KICK   = 3'd2,
      CMD_POLL   = 3'd3,
      CMD_ACK    = 3'd4,
      CMD_INIT   = 3'd5
   } cmd_type;

   // registered slot lookup status
   typedef struct packed {
      logic hit;
      logic full;
   } look_type;

   // slot table update request
   typedef struct packed {
      logic clear_all;
      logic alloc;
      logic drop;
   } slot_upd_type;

endpackage

/* rtl/dbt_ram.sv */
// Single-port-write, registered-read memory for the pending counters.
module dbt_ram #(
   parameter int ADDR_WIDTH = 5,
   parameter int DATA_WIDTH = 16
) (
   input  logic                  clock,
   input  logic                  wr_en,
   input  logic [ADDR_WIDTH-1:0] wr_addr,
   input  logic [DATA_WIDTH-1:0] wr_data,
   input  logic                  rd_en,
   input  logic [ADDR_WIDTH-1:0] rd_addr,
   output logic [DATA_WIDTH-1:0] rd_data_ff
);

   localparam int DEPTH = 1 << ADDR_WIDTH;

   logic [DATA_WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

endmodule

/* rtl/dbt_slots.sv */
// Slot table: valid bits, identifiers, parallel id match and free-slot search.
module dbt_slots import dbt_pkg::*; #(
   parameter int DEVICES    = 8,
   parameter int ID_WIDTH   = 32,
   parameter int SLOT_WIDTH = 3
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic [ID_WIDTH-1:0]   key_id,
   output look_type              look_ff,
   output logic [SLOT_WIDTH-1:0] match_idx_ff,
   output logic [SLOT_WIDTH-1:0] free_idx_ff,
   input  slot_upd_type          upd,
   input  logic [SLOT_WIDTH-1:0] upd_idx,
   input  logic [ID_WIDTH-1:0]   new_id
);

   logic [DEVICES-1:0]  valid_ff;
   logic [ID_WIDTH-1:0] id_ff [DEVICES];

   look_type              look_in;
   logic [SLOT_WIDTH-1:0] match_idx_in;
   logic [SLOT_WIDTH-1:0] free_idx_in;

   // lowest index wins for both searches
   always_comb begin
      look_in      = '0;
      match_idx_in = '0;
      free_idx_in  = '0;
      for (int i = DEVICES - 1; i >= 0; i--) begin
         if (valid_ff[i] && (id_ff[i] == key_id)) begin
            look_in.hit  = 1'b1;
            match_idx_in = SLOT_WIDTH'(i);
         end
         if (!valid_ff[i]) begin
            free_idx_in = SLOT_WIDTH'(i);
         end
      end
      look_in.full = &valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         look_ff  <= '0;
      end else begin
         look_ff <= look_in;
         priority if (upd.clear_all) begin
            valid_ff <= '0;
         end else if (upd.alloc) begin
            valid_ff[upd_idx] <= 1'b1;
         end else if (upd.drop) begin
            valid_ff[upd_idx] <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      match_idx_ff <= match_idx_in;
      free_idx_ff  <= free_idx_in;
      if (upd.alloc && !upd.clear_all) begin
         id_ff[upd_idx] <= new_id;
      end
   end

endmodule

/* rtl/doorbell_device_table_top.sv */
// Doorbell device table: command sequencer around the slot table and counter memory.
//
// Commands enter on the req_ channel (valid/ready); each produces exactly one
// transfer on the rsp_ channel carrying failed and result_value.
// One command is worked on at a time. After a command is accepted, it passes
// through lookup, memory read and execute, in which its result is registered;
// a successful add also sweeps the new slot's QUEUES counters to zero, one per
// cycle, before its result is registered. The block is ready for the next
// command in the cycle after the result is registered. The sequencer and the
// single write port of the counter memory set this pace.
// The result sits in an output register; if the receiver stalls, the block
// holds the finished result and waits before retiring the command.
// Reset empties the table, clears the identifier counter and leaves the
// block not ready: add fails until an init command. No clearing pass is
// needed, since a slot's counters are zeroed when the slot is allocated.
module doorbell_device_table_top import dbt_pkg::*; #(
   parameter int DEVICES     = 8,
   parameter int QUEUES      = 4,
   parameter int ID_WIDTH    = 32,
   parameter int COUNT_WIDTH = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [CMD_WIDTH-1:0]  req_command,
   input  logic [TYPE_WIDTH-1:0] req_device_type,
   input  logic [OUT_WIDTH-1:0]  req_device_id,
   input  logic [QIDX_WIDTH-1:0] req_queue_index,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic                  rsp_failed,
   output logic [OUT_WIDTH-1:0]  rsp_result_value
);

   localparam int SLOT_WIDTH = (DEVICES > 1) ? $clog2(DEVICES) : 1;
   localparam int QSEL_WIDTH = (QUEUES > 1) ? $clog2(QUEUES) : 1;
   localparam int ADDR_WIDTH = SLOT_WIDTH + QSEL_WIDTH;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOOK,
      ST_MEM,
      ST_EXEC,
      ST_CLEAR
   } state_type;

   state_type             state_ff;
   cmd_type               cmd_ff;
   logic [TYPE_WIDTH-1:0] type_ff;
   logic [OUT_WIDTH-1:0]  id_ff;
   logic [QIDX_WIDTH-1:0] queue_ff;
   logic                  ready_flag_ff;
   logic [ID_WIDTH-1:0]   id_counter_ff;
   logic [QSEL_WIDTH-1:0] sweep_ff;
   logic                  rsp_valid_ff;
   logic                  rsp_failed_ff;
   logic [OUT_WIDTH-1:0]  rsp_value_ff;

   look_type              look_ff;
   logic [SLOT_WIDTH-1:0] match_idx_ff;
   logic [SLOT_WIDTH-1:0] free_idx_ff;
   slot_upd_type          upd;
   logic [SLOT_WIDTH-1:0] upd_idx;

   logic                   ram_we;
   logic [ADDR_WIDTH-1:0]  ram_waddr;
   logic [COUNT_WIDTH-1:0] ram_wdata;
   logic                   ram_re;
   logic [ADDR_WIDTH-1:0]  target_addr;
   logic [COUNT_WIDTH-1:0] count;

   logic                  rsp_free;
   logic                  queue_ok;
   logic                  target_ok;
   logic                  add_ok;
   logic                  last_sweep;
   logic [ID_WIDTH-1:0]   next_id;
   logic                  exec_fail;
   logic [OUT_WIDTH-1:0]  exec_value;
   logic                  push;

   dbt_slots #(
      .DEVICES    (DEVICES),
      .ID_WIDTH   (ID_WIDTH),
      .SLOT_WIDTH (SLOT_WIDTH)
   ) u_slots (
      .clock        (clock),
      .reset        (reset),
      .key_id       (ID_WIDTH'(id_ff)),
      .look_ff      (look_ff),
      .match_idx_ff (match_idx_ff),
      .free_idx_ff  (free_idx_ff),
      .upd          (upd),
      .upd_idx      (upd_idx),
      .new_id       (next_id)
   );

   dbt_ram #(
      .ADDR_WIDTH (ADDR_WIDTH),
      .DATA_WIDTH (COUNT_WIDTH)
   ) u_ram (
      .clock      (clock),
      .wr_en      (ram_we),
      .wr_addr    (ram_waddr),
      .wr_data    (ram_wdata),
      .rd_en      (ram_re),
      .rd_addr    (target_addr),
      .rd_data_ff (count)
   );

   assign req_ready        = (state_ff == ST_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_failed       = rsp_failed_ff;
   assign rsp_result_value = rsp_value_ff;

   assign rsp_free    = !rsp_valid_ff || rsp_ready;
   assign queue_ok    = {1'b0, queue_ff} < (QIDX_WIDTH + 1)'(QUEUES);
   assign target_ok   = look_ff.hit && queue_ok;
   assign next_id     = id_counter_ff + 1'b1;
   assign add_ok      = ready_flag_ff && (type_ff <= MAX_DEV_TYPE) &&
                        (id_counter_ff != '1) && !look_ff.full;
   assign last_sweep  = (sweep_ff == QSEL_WIDTH'(QUEUES - 1));
   assign target_addr = {match_idx_ff, queue_ff[QSEL_WIDTH-1:0]};
   assign ram_re      = (state_ff == ST_MEM);

   always_comb begin
      exec_fail  = 1'b1;
      exec_value = '0;
      unique case (cmd_ff)
         CMD_INIT: begin
            exec_fail = 1'b0;
         end
         CMD_ADD: begin
            exec_fail  = !add_ok;
            exec_value = add_ok ? OUT_WIDTH'(next_id) : '0;
         end
         CMD_DELETE: begin
            exec_fail = !look_ff.hit;
         end
         CMD_KICK: begin
            exec_fail = !(target_ok && (count != '1));
         end
         CMD_POLL: begin
            exec_fail  = !target_ok;
            exec_value = target_ok ? OUT_WIDTH'(count) : '0;
         end
         CMD_ACK: begin
            exec_fail = !(target_ok && (count != '0));
         end
         default: begin
            exec_fail = 1'b1;
         end
      endcase
   end

   always_comb begin
      push = ((state_ff == ST_EXEC) && rsp_free && !((cmd_ff == CMD_ADD) && add_ok)) ||
             ((state_ff == ST_CLEAR) && last_sweep && rsp_free);

      ram_we    = 1'b0;
      ram_waddr = target_addr;
      ram_wdata = '0;
      if (state_ff == ST_CLEAR) begin
         ram_we    = 1'b1;
         ram_waddr = {free_idx_ff, sweep_ff};
      end else if (push && !exec_fail && (cmd_ff == CMD_KICK)) begin
         ram_we    = 1'b1;
         ram_wdata = count + 1'b1;
      end else if (push && !exec_fail && (cmd_ff == CMD_ACK)) begin
         ram_we    = 1'b1;
         ram_wdata = count - 1'b1;
      end

      upd.clear_all = push && (cmd_ff == CMD_INIT);
      upd.alloc     = push && (cmd_ff == CMD_ADD) && !exec_fail;
      upd.drop      = push && (cmd_ff == CMD_DELETE) && !exec_fail;
      upd_idx       = (cmd_ff == CMD_ADD) ? free_idx_ff : match_idx_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         ready_flag_ff <= 1'b0;
         id_counter_ff <= '0;
         sweep_ff      <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (push) begin
            rsp_valid_ff  <= 1'b1;
            rsp_failed_ff <= exec_fail;
            rsp_value_ff  <= exec_value;
         end else if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (upd.clear_all) begin
            ready_flag_ff <= 1'b1;
            id_counter_ff <= '0;
         end
         if (upd.alloc) begin
            id_counter_ff <= next_id;
         end

         unique case (state_ff)
            ST_IDLE: begin
               if (req_valid) begin
                  cmd_ff   <= cmd_type'(req_command);
                  type_ff  <= req_device_type;
                  id_ff    <= req_device_id;
                  queue_ff <= req_queue_index;
                  state_ff <= ST_LOOK;
               end
            end
            ST_LOOK: begin
               state_ff <= ST_MEM;
            end
            ST_MEM: begin
               state_ff <= ST_EXEC;
            end
            ST_EXEC: begin
               if ((cmd_ff == CMD_ADD) && add_ok) begin
                  sweep_ff <= '0;
                  state_ff <= ST_CLEAR;
               end else if (rsp_free) begin
                  state_ff <= ST_IDLE;
               end
            end
            ST_CLEAR: begin
               if (!last_sweep) begin
                  sweep_ff <= sweep_ff + 1'b1;
               end else if (rsp_free) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

`ifndef ASSERT_OFF
   a_reset_no_rsp: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid right after reset");

   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_failed) |-> (rsp_result_value == '0))
      else $error("failed response carries a nonzero value");

   a_ram_write_state: assert property (@(posedge clock) disable iff (reset)
      ram_we |-> ((state_ff == ST_EXEC) || (state_ff == ST_CLEAR)))
      else $error("counter memory written outside execute or clear");

   a_counter_monotonic: assert property (@(posedge clock) disable iff (reset)
      !upd.clear_all |=> (id_counter_ff >= $past(id_counter_ff)))
      else $error("identifier counter went backwards without init");

   a_alloc_ok: assert property (@(posedge clock) disable iff (reset)
      upd.alloc |-> (ready_flag_ff && !look_ff.full && (id_counter_ff != '1)))
      else $error("slot allocated while add should fail");
`endif

endmodule

/* verif/tb_doorbell_device_table_top.sv */
// Self-checking testbench for the doorbell device table: directed, random and stall traffic.
module tb_doorbell_device_table_top;
   import dbt_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int DEVICES         = 8;
   localparam int QUEUES          = 4;
   localparam int ID_WIDTH        = 32;
   localparam int COUNT_WIDTH     = 16;
   localparam int RANDOM_ITEMS    = 850;
   localparam int BURST_KICKS     = 40;
   localparam int LONG_HOLD       = 200;
   localparam int SETTLE_CYCLES   = 20;
   localparam int WATCHDOG_LIMIT  = 2000;
   localparam int QIDX_MAX        = (1 << QIDX_WIDTH) - 1;

   // command codes the block must reject
   localparam logic [CMD_WIDTH-1:0] CMD_BAD_LO = 3'd6;
   localparam logic [CMD_WIDTH-1:0] CMD_BAD_HI = 3'd7;

   typedef struct packed {
      logic                 failed;
      logic [OUT_WIDTH-1:0] value;
   } doorbell_rsp_type;

   class device_table_mirror;
      bit                   is_ready;
      bit [ID_WIDTH-1:0]    last_id;
      bit                   slot_used[DEVICES];
      bit [ID_WIDTH-1:0]    slot_ident[DEVICES];
      bit [TYPE_WIDTH-1:0]  slot_kind[DEVICES];
      bit [COUNT_WIDTH-1:0] doorbells[DEVICES*QUEUES];
      doorbell_rsp_type     due_results[$];
      int                   mismatches;
      int                   checked;
      int                   rejected;
      int                   full_rejects;

      function new();
         clear_table();
      endfunction

      function void clear_table();
         last_id = '0;
         for (int i = 0; i < DEVICES; i++) begin
            slot_used[i]  = 1'b0;
            slot_ident[i] = '0;
            slot_kind[i]  = '0;
         end
         for (int i = 0; i < DEVICES*QUEUES; i++)
            doorbells[i] = '0;
      endfunction

      function int find_slot(logic [OUT_WIDTH-1:0] ident);
         for (int i = 0; i < DEVICES; i++)
            if (slot_used[i] && slot_ident[i] == ID_WIDTH'(ident))
               return i;
         return -1;
      endfunction

      function bit pick_live_id(output logic [OUT_WIDTH-1:0] ident);
         int live[$];
         for (int i = 0; i < DEVICES; i++)
            if (slot_used[i])
               live.push_back(i);
         if (live.size() == 0)
            return 1'b0;
         ident = OUT_WIDTH'(slot_ident[live[$urandom_range(0, live.size() - 1)]]);
         return 1'b1;
      endfunction

      // Apply one accepted command to the mirror and queue the result it must produce.
      function void note_command(logic [CMD_WIDTH-1:0] cmd, logic [TYPE_WIDTH-1:0] kind,
                                 logic [OUT_WIDTH-1:0] ident, logic [QIDX_WIDTH-1:0] qidx);
         doorbell_rsp_type r;
         int               s;
         int               e;
         r.failed = 1'b1;
         r.value  = '0;
         s = -1;
         case (cmd)
            CMD_INIT: begin
               clear_table();
               is_ready = 1'b1;
               r.failed = 1'b0;
            end
            CMD_ADD: begin
               if (is_ready && kind <= MAX_DEV_TYPE && last_id != '1) begin
                  for (int i = 0; i < DEVICES; i++)
                     if (!slot_used[i] && s < 0)
                        s = i;
                  if (s < 0) begin
                     full_rejects++;
                  end else begin
                     last_id++;
                     slot_used[s]  = 1'b1;
                     slot_ident[s] = last_id;
                     slot_kind[s]  = kind;
                     for (int k = 0; k < QUEUES; k++)
                        doorbells[s*QUEUES + k] = '0;
                     r.failed = 1'b0;
                     r.value  = OUT_WIDTH'(last_id);
                  end
               end
            end
            CMD_DELETE: begin
               s = find_slot(ident);
               if (s >= 0) begin
                  slot_used[s]  = 1'b0;
                  slot_ident[s] = '0;
                  r.failed      = 1'b0;
               end
            end
            CMD_KICK, CMD_POLL, CMD_ACK: begin
               s = find_slot(ident);
               if (s >= 0 && qidx < QUEUES) begin
                  e = s*QUEUES + int'(qidx);
                  if (cmd == CMD_KICK) begin
                     // saturates at all-ones and reports failure
                     if (doorbells[e] != '1) begin
                        doorbells[e]++;
                        r.failed = 1'b0;
                     end
                  end else if (cmd == CMD_POLL) begin
                     r.value  = OUT_WIDTH'(doorbells[e]);
                     r.failed = 1'b0;
                  end else if (doorbells[e] != '0) begin
                     doorbells[e]--;
                     r.failed = 1'b0;
                  end
               end
            end
            default: begin
            end
         endcase
         due_results.push_back(r);
      endfunction

      function void check_result(logic failed, logic [OUT_WIDTH-1:0] value);
         doorbell_rsp_type x;
         if (due_results.size() == 0) begin
            $error("result transfer with nothing expected: failed=%0b result_value=%0h",
                   failed, value);
            mismatches++;
            return;
         end
         x = due_results.pop_front();
         checked++;
         if (x.failed)
            rejected++;
         if (failed !== x.failed) begin
            $error("failed: expected %0b, actual %0b", x.failed, failed);
            mismatches++;
         end
         if (value !== x.value) begin
            $error("result_value: expected %0h, actual %0h", x.value, value);
            mismatches++;
         end
      endfunction
   endclass

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   logic [CMD_WIDTH-1:0]  req_command = '0;
   logic [TYPE_WIDTH-1:0] req_device_type = '0;
   logic [OUT_WIDTH-1:0]  req_device_id = '0;
   logic [QIDX_WIDTH-1:0] req_queue_index = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   logic                  rsp_failed;
   logic [OUT_WIDTH-1:0]  rsp_result_value;

   device_table_mirror board;
   int                 sent;
   int                 rsp_hold_cycles;
   int                 stalled_cycles;
   bit                 no_gaps;
   logic [OUT_WIDTH-1:0] sat_id;

   doorbell_device_table_top #(
      .DEVICES     (DEVICES),
      .QUEUES      (QUEUES),
      .ID_WIDTH    (ID_WIDTH),
      .COUNT_WIDTH (COUNT_WIDTH)
   ) dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_command      (req_command),
      .req_device_type  (req_device_type),
      .req_device_id    (req_device_id),
      .req_queue_index  (req_queue_index),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_failed       (rsp_failed),
      .rsp_result_value (rsp_result_value)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Watchdog: cycles with no transfer on either channel.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         stalled_cycles <= 0;
      end else if (stalled_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog: no transfer for %0d cycles", stalled_cycles);
         $display("tb_doorbell_device_table_top NOT OK");
         $finish;
      end else begin
         stalled_cycles <= stalled_cycles + 1;
      end
   end

   // Valid is only dropped when a gap follows, so it never toggles within one step.
   task automatic issue_command(input logic [CMD_WIDTH-1:0] cmd,
                                input logic [TYPE_WIDTH-1:0] kind,
                                input logic [OUT_WIDTH-1:0] ident,
                                input logic [QIDX_WIDTH-1:0] qidx);
      int gap;
      gap = no_gaps ? 0 : $urandom_range(0, 8);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_command     <= cmd;
      req_device_type <= kind;
      req_device_id   <= ident;
      req_queue_index <= qidx;
      do @(posedge clock); while (!req_ready);
      board.note_command(cmd, kind, ident, qidx);
      sent++;
   endtask

   task automatic issue_random();
      int                    roll;
      logic [CMD_WIDTH-1:0]  cmd;
      logic [TYPE_WIDTH-1:0] kind;
      logic [OUT_WIDTH-1:0]  ident;
      logic [QIDX_WIDTH-1:0] qidx;
      roll = $urandom_range(0, 99);
      if (roll < 2)
         cmd = CMD_INIT;
      else if (roll == 2)
         cmd = CMD_BAD_LO;
      else if (roll == 3)
         cmd = CMD_BAD_HI;
      else if (roll < 24)
         cmd = CMD_ADD;
      else if (roll < 32)
         cmd = CMD_DELETE;
      else if (roll < 57)
         cmd = CMD_KICK;
      else if (roll < 72)
         cmd = CMD_POLL;
      else
         cmd = CMD_ACK;
      kind = ($urandom_range(0, 9) == 0) ? TYPE_WIDTH'(MAX_DEV_TYPE + 1)
                                         : TYPE_WIDTH'($urandom_range(0, MAX_DEV_TYPE));
      // mostly live ids; small ids catch stale ones, full-range ids cover every bit
      roll = $urandom_range(0, 9);
      if (roll >= 8 || !board.pick_live_id(ident))
         ident = (roll == 9) ? OUT_WIDTH'($urandom_range(0, 64)) : OUT_WIDTH'($urandom);
      qidx = ($urandom_range(0, 9) == 0) ? QIDX_WIDTH'($urandom_range(QUEUES, QIDX_MAX))
                                         : QIDX_WIDTH'($urandom_range(0, QUEUES - 1));
      issue_command(cmd, kind, ident, qidx);
   endtask

   task automatic wait_drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (board.due_results.size() != 0);
   endtask

   task automatic receive_results();
      int stall;
      forever begin
         if (rsp_hold_cycles > 0) begin
            stall = rsp_hold_cycles;
            rsp_hold_cycles = 0;
         end else begin
            stall = no_gaps ? 0 : $urandom_range(0, 8);
         end
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
         board.check_result(rsp_failed, rsp_result_value);
      end
   endtask

   initial begin
      board = new();
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      fork
         receive_results();
      join_none

      // directed: not-ready block, then the basic commands and their rejections
      issue_command(CMD_ADD, '0, '0, '0);
      issue_command(CMD_KICK, '0, '0, '0);
      issue_command(CMD_BAD_LO, '0, '0, '0);
      issue_command(CMD_INIT, '0, '0, '0);
      issue_command(CMD_ADD, TYPE_WIDTH'(MAX_DEV_TYPE + 1), '0, '0);
      issue_command(CMD_ADD, '0, '0, '0);
      issue_command(CMD_ADD, TYPE_WIDTH'(1), '0, '0);
      issue_command(CMD_ADD, MAX_DEV_TYPE, '0, '0);
      issue_command(CMD_KICK, '0, 32'd1, '0);
      issue_command(CMD_KICK, '0, 32'd1, QIDX_WIDTH'(QUEUES - 1));
      issue_command(CMD_KICK, '0, 32'd1, QIDX_WIDTH'(QUEUES));
      issue_command(CMD_POLL, '0, 32'd1, '0);
      issue_command(CMD_ACK, '0, 32'd1, '0);
      issue_command(CMD_ACK, '0, 32'd1, '0);
      issue_command(CMD_POLL, '0, '1, '0);
      issue_command(CMD_DELETE, '0, 32'd2, '0);
      issue_command(CMD_DELETE, '0, 32'd2, '0);
      // fill the free slots, the last add hits a full table
      repeat (DEVICES - 1)
         issue_command(CMD_ADD, TYPE_WIDTH'($urandom_range(0, MAX_DEV_TYPE)), '0, '0);
      issue_command(CMD_BAD_HI, '1, '1, QIDX_WIDTH'(QIDX_MAX));

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n == 300)
            rsp_hold_cycles = LONG_HOLD;
         if (n == 450)
            no_gaps = 1'b1;
         if (n == 550)
            no_gaps = 1'b0;
         if (n == 650)
            wait_drain();
         issue_random();
      end

      // back-to-back kicks on one queue of a fresh device, then read and drain one
      no_gaps = 1'b1;
      issue_command(CMD_INIT, '0, '0, '0);
      issue_command(CMD_ADD, '0, '0, '0);
      sat_id = OUT_WIDTH'(board.last_id);
      repeat (BURST_KICKS)
         issue_command(CMD_KICK, '0, sat_id, QIDX_WIDTH'(QUEUES - 1));
      issue_command(CMD_POLL, '0, sat_id, QIDX_WIDTH'(QUEUES - 1));
      issue_command(CMD_ACK, '0, sat_id, QIDX_WIDTH'(QUEUES - 1));
      issue_command(CMD_POLL, '0, sat_id, QIDX_WIDTH'(QUEUES - 1));
      no_gaps = 1'b0;

      wait_drain();
      repeat (SETTLE_CYCLES) @(posedge clock);
      $display("%0d commands sent, %0d results checked, %0d of them rejections",
               sent, board.checked, board.rejected);
      $display("full-table adds: %0d; one queue kicked %0d times back to back",
               board.full_rejects, BURST_KICKS);
      if (board.mismatches == 0 && board.due_results.size() == 0)
         $display("tb_doorbell_device_table_top OK");
      else
         $display("tb_doorbell_device_table_top NOT OK");
      $finish;
   end

endmodule
